// ===== rtl/bmhpq_pkg.sv =====
// Shared types and constants for the binary max-heap priority queue.
// No dependencies; used by bmhpq_store and binary_max_heap_priority_queue_unit.
`default_nettype none

package bmhpq_pkg;

    localparam int HEAP_DEPTH_DEF = 1024;
    localparam int ENTRY_W        = 64;
    localparam int FIELD_W        = 32;
    localparam int CAP_W          = 11;
    localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

    // Register index is taken from paddr[2]; the capacity register is index 0
    localparam logic REG_CAPACITY = 1'b0;

    typedef enum logic {
        OP_INSERT  = 1'b0,
        OP_EXTRACT = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_EX_ROOT,
        S_EX_LAST,
        S_DN_RD,
        S_DN_LEFT,
        S_DN_RIGHT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_store_ctl;

endpackage

`default_nettype wire

// ===== rtl/bmhpq_store.sv =====
// Heap entry store: one write port, one read port with registered read data.
// Depends on bmhpq_pkg for the entry width and the access control struct.
`default_nettype none

module bmhpq_store #(
    parameter int DEPTH = bmhpq_pkg::HEAP_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                         i_clk,
    input  wire bmhpq_pkg::t_store_ctl        i_ctl,
    input  wire logic [AW-1:0]                i_rd_addr,
    input  wire logic [AW-1:0]                i_wr_addr,
    input  wire logic [bmhpq_pkg::ENTRY_W-1:0] i_wr_data,
    output logic      [bmhpq_pkg::ENTRY_W-1:0] o_rd_data
);

    logic [bmhpq_pkg::ENTRY_W-1:0] r_mem [DEPTH];
    logic [bmhpq_pkg::ENTRY_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== rtl/binary_max_heap_priority_queue_unit.sv =====
// Priority queue as a 1-based binary max-heap in a store with registered read data.
// Insert climbs from the new leaf, reading one parent per level; extract reads the root,
// then the last entry, and sifts it down reading the left and then the right child.
// The unit takes one word at a time: o_ready rises with the result word's o_valid, and a
// result waits in S_DONE while the previous one is not taken. Reset empties the heap, capacity 1024.
// Depends on bmhpq_pkg and bmhpq_store.
`default_nettype none

module binary_max_heap_priority_queue_unit #(
    parameter int HEAP_DEPTH = bmhpq_pkg::HEAP_DEPTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // input word channel
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic                          i_op,
    input  wire logic [bmhpq_pkg::FIELD_W-1:0] i_entry_data,
    input  wire logic [bmhpq_pkg::FIELD_W-1:0] i_entry_priority,
    // result word channel
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [1:0]                         o_status,
    output logic [bmhpq_pkg::FIELD_W-1:0]      o_out_data,
    output logic [bmhpq_pkg::FIELD_W-1:0]      o_out_priority,
    // configuration
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [2:0]                    paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    localparam int AW = $clog2(HEAP_DEPTH);
    localparam int PW = $clog2(HEAP_DEPTH + 1);
    localparam int EW = (PW > bmhpq_pkg::CAP_W) ? PW : bmhpq_pkg::CAP_W;
    localparam int FW = bmhpq_pkg::FIELD_W;
    localparam int NW = bmhpq_pkg::ENTRY_W;

    // ---------------- configuration ----------------
    logic [bmhpq_pkg::CAP_W-1:0] r_cap;
    logic                        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == bmhpq_pkg::REG_CAPACITY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= bmhpq_pkg::CAP_RESET;
        end else if (cfg_wr) begin
            r_cap <= pwdata[bmhpq_pkg::CAP_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == bmhpq_pkg::REG_CAPACITY) begin
            prdata = 32'(r_cap);
        end
    end

    // ---------------- control state ----------------
    bmhpq_pkg::t_state  r_state, n_state;
    logic [PW-1:0]      r_count, n_count;
    logic [PW-1:0]      r_pos, n_pos;
    logic [NW-1:0]      r_x, n_x;
    logic [NW-1:0]      r_left, n_left;
    bmhpq_pkg::t_status r_res_status, n_res_status;
    logic [FW-1:0]      r_res_data, n_res_data;
    logic [FW-1:0]      r_res_prio, n_res_prio;
    logic               r_out_valid, n_out_valid;
    bmhpq_pkg::t_status r_out_status, n_out_status;
    logic [FW-1:0]      r_out_data, n_out_data;
    logic [FW-1:0]      r_out_prio, n_out_prio;

    // store access
    bmhpq_pkg::t_store_ctl store_ctl;
    logic [PW-1:0]         rd_pos, wr_pos, rd_pos_m1, wr_pos_m1;
    logic [NW-1:0]         wr_data, rd_data;

    // derived values
    logic [EW-1:0]   count_ext, cap_ext, eff_cap;
    logic            full;
    logic            accept;
    logic [PW:0]     l_idx, r_idx, count_w;
    logic [PW-1:0]   parent;
    logic            x_lt_left, x_lt_rd, left_lt_rd, rd_lt_x;

    assign count_ext = EW'(r_count);
    assign cap_ext   = EW'(r_cap);
    assign eff_cap   = (cap_ext > EW'(HEAP_DEPTH)) ? EW'(HEAP_DEPTH) : cap_ext;
    assign full      = (count_ext >= eff_cap);

    assign o_ready = (r_state == bmhpq_pkg::S_IDLE);
    assign accept  = i_valid && o_ready;

    assign l_idx   = {r_pos, 1'b0};
    assign r_idx   = {r_pos, 1'b1};
    assign count_w = {1'b0, r_count};
    assign parent  = r_pos >> 1;

    assign x_lt_left  = $signed(r_x[FW-1:0])    < $signed(rd_data[FW-1:0]);
    assign x_lt_rd    = $signed(r_x[FW-1:0])    < $signed(rd_data[FW-1:0]);
    assign left_lt_rd = $signed(r_left[FW-1:0]) < $signed(rd_data[FW-1:0]);
    assign rd_lt_x    = $signed(rd_data[FW-1:0]) < $signed(r_x[FW-1:0]);

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_pos        = r_pos;
        n_x          = r_x;
        n_left       = r_left;
        n_res_status = r_res_status;
        n_res_data   = r_res_data;
        n_res_prio   = r_res_prio;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_data   = r_out_data;
        n_out_prio   = r_out_prio;
        store_ctl    = '0;
        rd_pos       = r_pos;
        wr_pos       = r_pos;
        wr_data      = r_x;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            bmhpq_pkg::S_IDLE: begin
                if (accept) begin
                    n_res_status = bmhpq_pkg::ST_DONE;
                    n_res_data   = '0;
                    n_res_prio   = '0;
                    if (i_op == bmhpq_pkg::OP_INSERT) begin
                        if (full) begin
                            n_res_status = bmhpq_pkg::ST_OVERFLOW;
                            n_state      = bmhpq_pkg::S_DONE;
                        end else begin
                            n_count = r_count + PW'(1);
                            n_pos   = r_count + PW'(1);
                            n_x     = {i_entry_data, i_entry_priority};
                            n_state = bmhpq_pkg::S_UP_RD;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_res_status = bmhpq_pkg::ST_UNDERFLOW;
                            n_state      = bmhpq_pkg::S_DONE;
                        end else begin
                            // fetch the root
                            store_ctl.rd_en = 1'b1;
                            rd_pos          = PW'(1);
                            n_state         = bmhpq_pkg::S_EX_ROOT;
                        end
                    end
                end
            end

            bmhpq_pkg::S_UP_RD: begin
                if (r_pos == PW'(1)) begin
                    store_ctl.wr_en = 1'b1;
                    n_state         = bmhpq_pkg::S_DONE;
                end else begin
                    store_ctl.rd_en = 1'b1;
                    rd_pos          = parent;
                    n_state         = bmhpq_pkg::S_UP_CMP;
                end
            end

            bmhpq_pkg::S_UP_CMP: begin
                store_ctl.wr_en = 1'b1;
                if (rd_lt_x) begin
                    // move parent down into the hole, climb
                    wr_data = rd_data;
                    n_pos   = parent;
                    n_state = bmhpq_pkg::S_UP_RD;
                end else begin
                    n_state = bmhpq_pkg::S_DONE;
                end
            end

            bmhpq_pkg::S_EX_ROOT: begin
                n_res_data      = rd_data[NW-1:FW];
                n_res_prio      = rd_data[FW-1:0];
                store_ctl.rd_en = 1'b1;
                rd_pos          = r_count;
                n_state         = bmhpq_pkg::S_EX_LAST;
            end

            bmhpq_pkg::S_EX_LAST: begin
                n_x     = rd_data;
                n_count = r_count - PW'(1);
                n_pos   = PW'(1);
                n_state = (r_count == PW'(1)) ? bmhpq_pkg::S_DONE : bmhpq_pkg::S_DN_RD;
            end

            bmhpq_pkg::S_DN_RD: begin
                if (l_idx > count_w) begin
                    store_ctl.wr_en = 1'b1;
                    n_state         = bmhpq_pkg::S_DONE;
                end else begin
                    store_ctl.rd_en = 1'b1;
                    rd_pos          = l_idx[PW-1:0];
                    n_state         = bmhpq_pkg::S_DN_LEFT;
                end
            end

            bmhpq_pkg::S_DN_LEFT: begin
                n_left = rd_data;
                if (r_idx <= count_w) begin
                    store_ctl.rd_en = 1'b1;
                    rd_pos          = r_idx[PW-1:0];
                    n_state         = bmhpq_pkg::S_DN_RIGHT;
                end else begin
                    store_ctl.wr_en = 1'b1;
                    if (x_lt_left) begin
                        wr_data = rd_data;
                        n_pos   = l_idx[PW-1:0];
                        n_state = bmhpq_pkg::S_DN_RD;
                    end else begin
                        n_state = bmhpq_pkg::S_DONE;
                    end
                end
            end

            bmhpq_pkg::S_DN_RIGHT: begin
                store_ctl.wr_en = 1'b1;
                // left first, right only if strictly above the best so far
                if ($signed(r_x[FW-1:0]) < $signed(r_left[FW-1:0])) begin
                    if (left_lt_rd) begin
                        wr_data = rd_data;
                        n_pos   = r_idx[PW-1:0];
                    end else begin
                        wr_data = r_left;
                        n_pos   = l_idx[PW-1:0];
                    end
                    n_state = bmhpq_pkg::S_DN_RD;
                end else if (x_lt_rd) begin
                    wr_data = rd_data;
                    n_pos   = r_idx[PW-1:0];
                    n_state = bmhpq_pkg::S_DN_RD;
                end else begin
                    n_state = bmhpq_pkg::S_DONE;
                end
            end

            bmhpq_pkg::S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_data   = r_res_data;
                    n_out_prio   = r_res_prio;
                    n_state      = bmhpq_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = bmhpq_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bmhpq_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos        <= n_pos;
        r_x          <= n_x;
        r_left       <= n_left;
        r_res_status <= n_res_status;
        r_res_data   <= n_res_data;
        r_res_prio   <= n_res_prio;
        r_out_status <= n_out_status;
        r_out_data   <= n_out_data;
        r_out_prio   <= n_out_prio;
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_out_status;
    assign o_out_data     = r_out_data;
    assign o_out_priority = r_out_prio;

    // heap position p lives at address p-1
    assign rd_pos_m1 = rd_pos - PW'(1);
    assign wr_pos_m1 = wr_pos - PW'(1);

    bmhpq_store #(
        .DEPTH (HEAP_DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_ctl     (store_ctl),
        .i_rd_addr (rd_pos_m1[AW-1:0]),
        .i_wr_addr (wr_pos_m1[AW-1:0]),
        .i_wr_data (wr_data),
        .o_rd_data (rd_data)
    );

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        EW'(r_count) <= EW'(HEAP_DEPTH))
        else $error("entry count above heap depth");

    a_wr_in_heap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        store_ctl.wr_en |-> (wr_pos != '0) && (wr_pos <= r_count))
        else $error("store write outside live heap");

    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(store_ctl.wr_en && store_ctl.rd_en))
        else $error("read and write issued together");

    a_full_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_op == bmhpq_pkg::OP_INSERT) && full)
            |=> (r_state == bmhpq_pkg::S_DONE) && (r_res_status == bmhpq_pkg::ST_OVERFLOW)
                && $stable(r_count))
        else $error("overflow insert did not report or changed the count");

    a_extract_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bmhpq_pkg::S_EX_LAST) |=> r_count == $past(r_count) - PW'(1))
        else $error("extract did not drop the count by one");
`endif

endmodule

`default_nettype wire

// ===== sim/tb_binary_max_heap_priority_queue_unit.sv =====
// Self-checking testbench for the binary max-heap priority queue unit.
// Drives insert/extract words and capacity writes, predicts every result word.
// Depends on bmhpq_pkg and the unit under rtl/.
`default_nettype none

module tb_binary_max_heap_priority_queue_unit;

    localparam int HEAP_SLOTS = bmhpq_pkg::HEAP_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam logic [2:0] ADDR_CAPACITY = {bmhpq_pkg::REG_CAPACITY, 2'b00};
    localparam logic [2:0] ADDR_SPARE = {~bmhpq_pkg::REG_CAPACITY, 2'b00};
    localparam bmhpq_pkg::t_op OP_INS = bmhpq_pkg::OP_INSERT;
    localparam bmhpq_pkg::t_op OP_EXT = bmhpq_pkg::OP_EXTRACT;

    typedef struct packed {
        bmhpq_pkg::t_status st;
        logic [31:0]        dat;
        logic [31:0]        pri;
    } t_heap_result;

    typedef struct packed {
        logic           set_cap;
        logic [31:0]    cap_word;
        bmhpq_pkg::t_op op;
        logic [31:0]    dat;
        logic [31:0]    pri;
        logic           typed;
        t_heap_result   want;
    } t_directed_row;

    localparam t_heap_result DONE_EMPTY  = '{bmhpq_pkg::ST_DONE, 32'h0, 32'h0};
    localparam t_heap_result OVERFLOWED  = '{bmhpq_pkg::ST_OVERFLOW, 32'h0, 32'h0};
    localparam t_heap_result UNDERFLOWED = '{bmhpq_pkg::ST_UNDERFLOW, 32'h0, 32'h0};
    localparam t_heap_result FROM_MODEL  = '0;

    // Rows with a capacity write apply it (while idle) before their own word.
    localparam t_directed_row DIRECTED_ROWS [25] = '{
        '{1'b0, 32'h0, OP_EXT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, UNDERFLOWED},
        '{1'b0, 32'h0, OP_INS, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, DONE_EMPTY},
        '{1'b0, 32'h0, OP_INS, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, DONE_EMPTY},
        '{1'b0, 32'h0, OP_INS, 32'h0000_0000, 32'h0000_0000, 1'b1, DONE_EMPTY},
        '{1'b0, 32'h0, OP_INS, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, DONE_EMPTY},
        '{1'b0, 32'h0, OP_INS, 32'h0000_0005, 32'h7FFF_FFFF, 1'b1, DONE_EMPTY},
        '{1'b0, 32'h0, OP_INS, 32'h0000_0006, 32'h0000_0000, 1'b1, DONE_EMPTY},
        '{1'b0, 32'h0, OP_EXT, 32'h1234_5678, 32'h7FFF_FFFF, 1'b0, FROM_MODEL},
        '{1'b0, 32'h0, OP_EXT, 32'h0000_0000, 32'h0000_0000, 1'b0, FROM_MODEL},
        '{1'b0, 32'h0, OP_EXT, 32'hFFFF_FFFF, 32'h8000_0000, 1'b0, FROM_MODEL},
        '{1'b0, 32'h0, OP_EXT, 32'h5A5A_5A5A, 32'hA5A5_A5A5, 1'b0, FROM_MODEL},
        '{1'b0, 32'h0, OP_EXT, 32'h0000_0001, 32'h0000_0001, 1'b0, FROM_MODEL},
        '{1'b0, 32'h0, OP_EXT, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, FROM_MODEL},
        '{1'b0, 32'h0, OP_EXT, 32'h0000_0000, 32'h0000_0000, 1'b1, UNDERFLOWED},
        // zero capacity, upper write bits set and dropped
        '{1'b1, 32'hFFFF_F800, OP_INS, 32'h0000_0001, 32'h0000_0001, 1'b1, OVERFLOWED},
        '{1'b0, 32'h0, OP_EXT, 32'h0000_0000, 32'h0000_0000, 1'b1, UNDERFLOWED},
        '{1'b1, 32'd1, OP_INS, 32'hAAAA_AAAA, 32'h5555_5555, 1'b1, DONE_EMPTY},
        '{1'b0, 32'h0, OP_INS, 32'h5555_5555, 32'hAAAA_AAAA, 1'b1, OVERFLOWED},
        // capacity above the store depth acts as the depth
        '{1'b1, 32'd2047, OP_INS, 32'h0000_0001, 32'h8000_0001, 1'b1, DONE_EMPTY},
        '{1'b0, 32'h0, OP_INS, 32'h0000_0002, 32'h7FFF_FFFE, 1'b1, DONE_EMPTY},
        // capacity dropped below the fill: held entries stay
        '{1'b1, 32'd1, OP_INS, 32'h0000_0003, 32'h0000_0003, 1'b1, OVERFLOWED},
        '{1'b0, 32'h0, OP_EXT, 32'h0000_0000, 32'h0000_0000, 1'b0, FROM_MODEL},
        '{1'b0, 32'h0, OP_EXT, 32'h0000_0000, 32'h0000_0000, 1'b0, FROM_MODEL},
        '{1'b0, 32'h0, OP_EXT, 32'h0000_0000, 32'h0000_0000, 1'b0, FROM_MODEL},
        '{1'b0, 32'h0, OP_EXT, 32'h0000_0000, 32'h0000_0000, 1'b1, UNDERFLOWED}
    };

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_ready;
    logic              i_op = 1'b0;
    logic [31:0]       i_entry_data = 32'h0;
    logic [31:0]       i_entry_priority = 32'h0;
    logic              o_valid;
    logic              i_ready = 1'b0;
    logic [1:0]        o_status;
    logic [31:0]       o_out_data;
    logic [31:0]       o_out_priority;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [2:0]        paddr = 3'h0;
    logic [31:0]       pwdata = 32'h0;
    logic [31:0]       prdata;
    logic              pready;

    // predicted heap contents
    logic [31:0]        heap_data [1:HEAP_SLOTS];
    logic signed [31:0] heap_prio [1:HEAP_SLOTS];
    int                 heap_fill = 0;
    logic [10:0]        heap_cap = bmhpq_pkg::CAP_RESET;

    t_heap_result results_due [$];
    t_heap_result due_word;
    int           mismatch_count = 0;
    int           cycle_count = 0;
    int           send_idle = 16;
    int           recv_idle = 70;
    logic         hold_req = 1'b0;
    logic         hold_taken = 1'b0;
    int           hold_left = 0;

    binary_max_heap_priority_queue_unit uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_op             (i_op),
        .i_entry_data     (i_entry_data),
        .i_entry_priority (i_entry_priority),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_status         (o_status),
        .o_out_data       (o_out_data),
        .o_out_priority   (o_out_priority),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d result words outstanding",
                     cycle_count, results_due.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic log_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%s", msg);
        end
    endtask

    function automatic void swap_entries(input int a, input int b);
        logic [31:0] tmp;
        tmp = heap_data[a];
        heap_data[a] = heap_data[b];
        heap_data[b] = tmp;
        tmp = heap_prio[a];
        heap_prio[a] = heap_prio[b];
        heap_prio[b] = tmp;
    endfunction

    // Apply one accepted word to the predicted heap and return its result word.
    function automatic t_heap_result heap_apply(input bmhpq_pkg::t_op op,
                                                input logic [31:0] d,
                                                input logic [31:0] p);
        t_heap_result r;
        int           lim;
        int           pos;
        int           best;
        int           lc;
        logic         moved;
        r = DONE_EMPTY;
        lim = (heap_cap > HEAP_SLOTS) ? HEAP_SLOTS : int'(heap_cap);
        if (op == bmhpq_pkg::OP_INSERT) begin
            if (heap_fill >= lim) begin
                r.st = bmhpq_pkg::ST_OVERFLOW;
            end else begin
                heap_fill++;
                pos = heap_fill;
                heap_data[pos] = d;
                heap_prio[pos] = p;
                while (pos > 1 && heap_prio[pos / 2] < heap_prio[pos]) begin
                    swap_entries(pos, pos / 2);
                    pos = pos / 2;
                end
            end
        end else if (heap_fill == 0) begin
            r.st = bmhpq_pkg::ST_UNDERFLOW;
        end else begin
            r.dat = heap_data[1];
            r.pri = heap_prio[1];
            heap_data[1] = heap_data[heap_fill];
            heap_prio[1] = heap_prio[heap_fill];
            heap_fill--;
            pos = 1;
            moved = 1'b1;
            // left child wins a tie with the right one
            while (moved) begin
                best = pos;
                lc = 2 * pos;
                if (lc <= heap_fill && heap_prio[best] < heap_prio[lc]) best = lc;
                if (lc + 1 <= heap_fill && heap_prio[best] < heap_prio[lc + 1]) best = lc + 1;
                moved = (best != pos);
                if (moved) begin
                    swap_entries(best, pos);
                    pos = best;
                end
            end
        end
        return r;
    endfunction

    // Offer one word, hold it until accepted, then record what it should return.
    task automatic issue_word(input bmhpq_pkg::t_op op, input logic [31:0] d,
                              input logic [31:0] p,
                              input logic typed, input t_heap_result typed_want);
        t_heap_result predicted;
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_op = op;
        i_entry_data = d;
        i_entry_priority = p;
        do @(posedge i_clk); while (!o_ready);
        predicted = heap_apply(op, d, p);
        results_due.push_back(typed ? typed_want : predicted);
    endtask

    task automatic apb_access(input logic wr, input logic [2:0] addr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        @(negedge i_clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = wr;
        paddr = addr;
        pwdata = wdata;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic check_capacity();
        logic [31:0] got;
        apb_access(1'b0, ADDR_CAPACITY, 32'h0, got);
        if (got !== {21'b0, heap_cap}) begin
            log_failure($sformatf("capacity readback: expected %0d, got %0d", heap_cap, got));
        end
    endtask

    // Drain the block before touching the register.
    task automatic set_capacity(input logic [31:0] value);
        logic [31:0] unused;
        @(negedge i_clk);
        i_valid = 1'b0;
        while (results_due.size() != 0 || !o_ready) @(posedge i_clk);
        apb_access(1'b1, ADDR_CAPACITY, value, unused);
        heap_cap = value[10:0];
        check_capacity();
    endtask

    task automatic run_phase(input int words, input int insert_pct);
        bmhpq_pkg::t_op op;
        logic [31:0]    pri;
        for (int n = 0; n < words; n++) begin
            op = ($urandom_range(0, 99) < insert_pct) ? OP_INS : OP_EXT;
            case ($urandom_range(0, 3))
                0: begin
                    // narrow range to force equal priorities
                    pri = $urandom_range(0, 15) - 8;
                end
                1: begin
                    case ($urandom_range(0, 3))
                        0: pri = 32'h8000_0000;
                        1: pri = 32'h7FFF_FFFF;
                        2: pri = 32'h0;
                        default: pri = 32'hFFFF_FFFF;
                    endcase
                end
                default: pri = $urandom;
            endcase
            issue_word(op, $urandom, pri, 1'b0, FROM_MODEL);
        end
    endtask

    always @(negedge i_clk) begin
        if (hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left = HOLD_OFF_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready = 1'b0;
        end else begin
            i_ready = ($urandom_range(0, 99) >= recv_idle);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (results_due.size() == 0) begin
                log_failure($sformatf("unexpected result word: status %0d data %0d prio %0d",
                                      o_status, $signed(o_out_data), $signed(o_out_priority)));
            end else begin
                due_word = results_due.pop_front();
                if (o_status !== due_word.st || o_out_data !== due_word.dat ||
                    o_out_priority !== due_word.pri) begin
                    log_failure($sformatf(
                        "result mismatch: expected status %0d data %0d prio %0d, got %0d %0d %0d",
                        due_word.st, $signed(due_word.dat), $signed(due_word.pri),
                        o_status, $signed(o_out_data), $signed(o_out_priority)));
                end
            end
        end
    end

    initial begin
        t_directed_row row;
        logic [31:0]   unused;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        check_capacity();
        for (int k = 0; k < $size(DIRECTED_ROWS); k++) begin
            row = DIRECTED_ROWS[k];
            if (row.set_cap) set_capacity(row.cap_word);
            issue_word(row.op, row.dat, row.pri, row.typed, row.want);
        end

        // a write to the unused address must leave the capacity alone
        @(negedge i_clk);
        i_valid = 1'b0;
        while (results_due.size() != 0 || !o_ready) @(posedge i_clk);
        apb_access(1'b1, ADDR_SPARE, 32'h0, unused);
        check_capacity();

        set_capacity(32'd5);
        run_phase(250, 50);

        send_idle = 70;
        recv_idle = 16;
        set_capacity(32'd1);
        run_phase(150, 50);

        send_idle = 0;
        recv_idle = 0;
        set_capacity(32'd1024);
        hold_req = 1'b1;
        run_phase(500, 75);

        set_capacity(32'd2047);
        run_phase(250, 20);

        @(negedge i_clk);
        i_valid = 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/bmhpq_pkg.sv
rtl/bmhpq_store.sv
rtl/binary_max_heap_priority_queue_unit.sv
sim/tb_binary_max_heap_priority_queue_unit.sv
